[rtl/dvp_pkg.sv]
// dvp_pkg: shared constants for the distance velocity profiler
// field widths, register indexes, reset values and item kind codes
// no dependencies
package dvp_pkg;

   localparam int POS_W   = 32;
   localparam int SPEED_W = 15;
   localparam int OUT_W   = 16;
   localparam int PROD_W  = 2 * POS_W;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_DIST = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PEAK_SPEED  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FLOOR_SPEED = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEER_CMD   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_REVERSE_DIR = 3'd4;

   localparam logic [SPEED_W-1:0] PEAK_RESET  = 15'd2458;
   localparam logic [SPEED_W-1:0] FLOOR_RESET = 15'd410;

   localparam logic [REQ_USER_W-1:0] KIND_POSE   = 2'd0;
   localparam logic [REQ_USER_W-1:0] KIND_PALLET = 2'd1;
   localparam logic [REQ_USER_W-1:0] KIND_TICK   = 2'd2;

   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] ROOT_LAST = 5'd31;
   localparam logic [CNT_W-1:0] DIV_LAST  = 5'd14;

endpackage

[rtl/distance_velocity_profiler.sv]
// distance_velocity_profiler: top level, triangular speed profile over distance
// one shared multiplier and one shared compare/subtract step serve sqrt and divide
// depends on dvp_pkg
//
// The block takes pose, pallet and tick items on the req stream and answers each
// tick with one speed/steer command on the rsp stream until it stops. It takes one
// item at a time. A pallet item, a first pose, an unused kind or a tick after the
// stop is handled in the idle state. A pose after an earlier pose runs an absolute
// difference, two squares through the shared 32x32 multiplier, a 65-bit sum and a
// 32-step bit-per-cycle square root, then the saturating add; an overflowing sum of
// squares saturates the distance and skips the root. A tick runs a half check, one
// product through the multiplier and a 15-step restoring divide, then waits while
// the rsp side holds the previous command; the stopping tick goes from the half check
// to the stop command, with the same wait. Speed is floor + (peak - floor) * 2d / target
// for distance d below half the target, else peak + (floor - peak) * (2d - target) /
// target, truncated toward zero; the stop command has zero speed and steering, halted
// set, stop_by_pallet set if a pallet caused it. After the stop only reset resumes commands.
module distance_velocity_profiler
   import dvp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x [31:0], pos_y [63:32], pallet_flag [64], zero [71:65]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type [1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // speed_out [15:0], steer_out [31:16], halted [32], stop_by_pallet [33], zero [39:34]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DX   = 4'd1;
   localparam logic [3:0] S_MX   = 4'd2;
   localparam logic [3:0] S_MY   = 4'd3;
   localparam logic [3:0] S_SUM  = 4'd4;
   localparam logic [3:0] S_ROOT = 4'd5;
   localparam logic [3:0] S_ADD  = 4'd6;
   localparam logic [3:0] S_TCHK = 4'd7;
   localparam logic [3:0] S_TMUL = 4'd8;
   localparam logic [3:0] S_DIV  = 4'd9;
   localparam logic [3:0] S_TFIN = 4'd10;
   localparam logic [3:0] S_STOP = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [POS_W-1:0]   last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic               have_last_ff, have_last_in;
   logic               pallet_ff, pallet_in;
   logic               done_ff, done_in;
   logic [POS_W-1:0]   travelled_ff, travelled_in;
   logic [POS_W-1:0]   op_a_ff, op_a_in, op_b_ff, op_b_in;
   logic [PROD_W-1:0]  acc_ff, acc_in, prod_ff, prod_in;
   logic               ovf_ff, ovf_in;
   logic [POS_W:0]     rem_ff, rem_in;
   logic [POS_W-1:0]   root_ff, root_in;
   logic [SPEED_W-1:0] base_ff, base_in;
   logic               sub_ff, sub_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   speed_ff, speed_in, steer_ff, steer_in;
   logic               halt_ff, halt_in, pstop_ff, pstop_in;
   logic [POS_W-1:0]   tgt_ff, tgt_in;
   logic [SPEED_W-1:0] peak_ff, peak_in, floor_ff, floor_in;
   logic [OUT_W-1:0]   steer_cfg_ff, steer_cfg_in;
   logic               rev_ff, rev_in;

   logic [PROD_W-1:0]  mul_out;
   logic [POS_W+2:0]   alu_a, alu_b;
   logic [POS_W+3:0]   alu_diff;
   logic               alu_ge;
   logic [POS_W:0]     sel_d;
   logic [POS_W-1:0]   abs_d;
   logic [POS_W:0]     two_t, over_t, sum_t;
   logic               first_half;
   logic [SPEED_W:0]   spd_diff;
   logic [SPEED_W-1:0] spd_mag;
   logic [OUT_W-1:0]   mag_v;
   logic               rsp_free;
   logic               req_xfer;

   assign mul_out  = op_a_ff * op_b_ff;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer = req_tvalid && req_tready;

   // shared compare/subtract step for the square root and the divide
   always_comb begin
      if (state_ff == S_ROOT) begin
         alu_a = {rem_ff, acc_ff[PROD_W-1 -: 2]};
         alu_b = {1'b0, root_ff, 2'b01};
      end else begin
         alu_a = {2'b00, rem_ff[POS_W-1:0], acc_ff[SPEED_W-1]};
         alu_b = {3'b000, tgt_ff};
      end
      alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
      alu_ge   = !alu_diff[POS_W+3];
   end

   always_comb begin
      sel_d = (state_ff == S_DX) ? ({x_ff[POS_W-1], x_ff} - {last_x_ff[POS_W-1], last_x_ff})
                                 : ({y_ff[POS_W-1], y_ff} - {last_y_ff[POS_W-1], last_y_ff});
      abs_d = sel_d[POS_W] ? POS_W'(-sel_d) : sel_d[POS_W-1:0];
   end

   always_comb begin
      two_t      = {travelled_ff, 1'b0};
      first_half = two_t < {1'b0, tgt_ff};
      over_t     = two_t - {1'b0, tgt_ff};
      sum_t      = {1'b0, travelled_ff} + {1'b0, root_ff};
      spd_diff   = {1'b0, peak_ff} - {1'b0, floor_ff};
      spd_mag    = spd_diff[SPEED_W] ? SPEED_W'(-spd_diff) : spd_diff[SPEED_W-1:0];
      mag_v      = sub_ff ? ({1'b0, base_ff} - {1'b0, root_ff[SPEED_W-1:0]})
                          : ({1'b0, base_ff} + {1'b0, root_ff[SPEED_W-1:0]});
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      have_last_in = have_last_ff;
      pallet_in    = pallet_ff;
      done_in      = done_ff;
      travelled_in = travelled_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      ovf_in       = ovf_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      base_in      = base_ff;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      speed_in     = speed_ff;
      steer_in     = steer_ff;
      halt_in      = halt_ff;
      pstop_in     = pstop_ff;
      tgt_in       = tgt_ff;
      peak_in      = peak_ff;
      floor_in     = floor_ff;
      steer_cfg_in = steer_cfg_ff;
      rev_in       = rev_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_TARGET_DIST: tgt_in       = csr_wdata[POS_W-1:0];
            CSR_PEAK_SPEED:  peak_in      = csr_wdata[SPEED_W-1:0];
            CSR_FLOOR_SPEED: floor_in     = csr_wdata[SPEED_W-1:0];
            CSR_STEER_CMD:   steer_cfg_in = csr_wdata[OUT_W-1:0];
            CSR_REVERSE_DIR: rev_in       = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_tuser)
                  KIND_POSE: begin
                     x_in = req_tdata[POS_W-1:0];
                     y_in = req_tdata[2*POS_W-1:POS_W];
                     if (have_last_ff) begin
                        state_in = S_DX;
                     end else begin
                        last_x_in    = req_tdata[POS_W-1:0];
                        last_y_in    = req_tdata[2*POS_W-1:POS_W];
                        have_last_in = 1'b1;
                     end
                  end
                  KIND_PALLET: begin
                     if (req_tdata[2*POS_W]) begin
                        pallet_in = 1'b1;
                     end
                  end
                  KIND_TICK: begin
                     if (!done_ff) begin
                        state_in = S_TCHK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DX: begin
            op_a_in  = abs_d;
            op_b_in  = abs_d;
            state_in = S_MX;
         end
         S_MX: begin
            acc_in   = mul_out;
            op_a_in  = abs_d;
            op_b_in  = abs_d;
            state_in = S_MY;
         end
         S_MY: begin
            prod_in  = mul_out;
            state_in = S_SUM;
         end
         S_SUM: begin
            {ovf_in, acc_in} = {1'b0, acc_ff} + {1'b0, prod_ff};
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = ROOT_LAST;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (ovf_ff) begin
               travelled_in = '1;
               last_x_in    = x_ff;
               last_y_in    = y_ff;
               state_in     = S_IDLE;
            end else begin
               rem_in  = alu_ge ? alu_diff[POS_W:0] : alu_a[POS_W:0];
               root_in = {root_ff[POS_W-2:0], alu_ge};
               acc_in  = {acc_ff[PROD_W-3:0], 2'b00};
               cnt_in  = cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_in = S_ADD;
               end
            end
         end
         S_ADD: begin
            travelled_in = sum_t[POS_W] ? '1 : sum_t[POS_W-1:0];
            last_x_in    = x_ff;
            last_y_in    = y_ff;
            state_in     = S_IDLE;
         end
         S_TCHK: begin
            if (pallet_ff || (travelled_ff >= tgt_ff)) begin
               done_in  = 1'b1;
               state_in = S_STOP;
            end else begin
               op_a_in = {{(POS_W-SPEED_W){1'b0}}, spd_mag};
               if (first_half) begin
                  op_b_in = two_t[POS_W-1:0];
                  base_in = floor_ff;
                  sub_in  = spd_diff[SPEED_W];
               end else begin
                  op_b_in = over_t[POS_W-1:0];
                  base_in = peak_ff;
                  sub_in  = !spd_diff[SPEED_W] && (spd_diff != '0);
               end
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            acc_in   = mul_out;
            rem_in   = {1'b0, mul_out[POS_W+SPEED_W-1:SPEED_W]};
            root_in  = '0;
            cnt_in   = DIV_LAST;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = alu_ge ? alu_diff[POS_W:0] : alu_a[POS_W:0];
            root_in = {root_ff[POS_W-2:0], alu_ge};
            acc_in  = {acc_ff[PROD_W-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_TFIN;
            end
         end
         S_TFIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               speed_in     = rev_ff ? OUT_W'(-mag_v) : mag_v;
               steer_in     = steer_cfg_ff;
               halt_in      = 1'b0;
               pstop_in     = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_STOP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               speed_in     = '0;
               steer_in     = '0;
               halt_in      = 1'b1;
               pstop_in     = pallet_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         have_last_ff <= 1'b0;
         pallet_ff    <= 1'b0;
         done_ff      <= 1'b0;
         travelled_ff <= '0;
         rsp_valid_ff <= 1'b0;
         tgt_ff       <= '0;
         peak_ff      <= PEAK_RESET;
         floor_ff     <= FLOOR_RESET;
         steer_cfg_ff <= '0;
         rev_ff       <= 1'b1;
      end else begin
         state_ff     <= state_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         have_last_ff <= have_last_in;
         pallet_ff    <= pallet_in;
         done_ff      <= done_in;
         travelled_ff <= travelled_in;
         rsp_valid_ff <= rsp_valid_in;
         tgt_ff       <= tgt_in;
         peak_ff      <= peak_in;
         floor_ff     <= floor_in;
         steer_cfg_ff <= steer_cfg_in;
         rev_ff       <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      op_a_ff  <= op_a_in;
      op_b_ff  <= op_b_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      ovf_ff   <= ovf_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      base_ff  <= base_in;
      sub_ff   <= sub_in;
      speed_ff <= speed_in;
      steer_ff <= steer_in;
      halt_ff  <= halt_in;
      pstop_ff <= pstop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*OUT_W-2){1'b0}}, pstop_ff, halt_ff, steer_ff, speed_ff};

   // once stopped, stays stopped until reset
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("stop latch cleared");

   a_stop_follows: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> state_ff == S_STOP)
      else $error("stop latched without stop command");

   // divider remainder must stay below the target
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < {1'b0, tgt_ff})
      else $error("divide remainder out of range");

   a_halt_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && halt_ff) |-> done_ff)
      else $error("halted command without stop");

endmodule

[tb/velocity_cmd_checker.sv]
// velocity_cmd_checker: watches the req, rsp and csr ports of the distance velocity profiler
// keeps its own copy of the profile registers and motion state, predicts every command
// depends on dvp_pkg
module velocity_cmd_checker
   import dvp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    cmds_due,
   output logic [POS_W-1:0]      walked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        by_pallet;
      logic        halted;
      logic [15:0] steer;
      logic [15:0] speed;
   } vel_cmd_type;

   vel_cmd_type pending_cmds[$];
   vel_cmd_type got;
   vel_cmd_type want;

   logic [POS_W-1:0]   cfg_target;
   logic [SPEED_W-1:0] cfg_peak;
   logic [SPEED_W-1:0] cfg_floor;
   logic [OUT_W-1:0]   cfg_steer;
   logic               cfg_reverse;

   logic [POS_W-1:0] dist_sum;
   logic [POS_W-1:0] prev_x;
   logic [POS_W-1:0] prev_y;
   logic             seen_pose;
   logic             pallet_latched;
   logic             stopped;

   function automatic logic [31:0] root_floor(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] acc;
      logic [63:0] probe;
      rem = v;
      acc = '0;
      for (int k = 31; k >= 0; k--) begin
         probe = 64'd1 << (2 * k);
         if (rem >= acc + probe) begin
            rem = rem - acc - probe;
            acc = (acc >> 1) + probe;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc[31:0];
   endfunction

   task automatic note_failure(input string msg);
      if (fail_count < 10) begin
         $display("mismatch: %s", msg);
      end
      fail_count++;
   endtask

   task automatic absorb_item(input logic [REQ_USER_W-1:0] kind,
                              input logic [REQ_DATA_W-1:0] data);
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] ax;
      logic [31:0] ay;
      logic [63:0] sx;
      logic [63:0] sy;
      logic [64:0] sq;
      logic [32:0] total;
      longint      dxl;
      longint      dyl;
      longint      goal;
      longint      twice;
      longint      pk;
      longint      fl;
      longint      v;
      vel_cmd_type cmd;
      x = data[31:0];
      y = data[63:32];
      case (kind)
         KIND_POSE: begin
            if (seen_pose) begin
               dxl = longint'($signed(x)) - longint'($signed(prev_x));
               dyl = longint'($signed(y)) - longint'($signed(prev_y));
               ax = 32'((dxl < 0) ? -dxl : dxl);
               ay = 32'((dyl < 0) ? -dyl : dyl);
               sx = {32'd0, ax} * {32'd0, ax};
               sy = {32'd0, ay} * {32'd0, ay};
               sq = {1'b0, sx} + {1'b0, sy};
               if (sq[64]) begin
                  dist_sum = '1;
               end else begin
                  total = {1'b0, dist_sum} + {1'b0, root_floor(sq[63:0])};
                  dist_sum = total[32] ? '1 : total[31:0];
               end
            end
            prev_x = x;
            prev_y = y;
            seen_pose = 1'b1;
         end
         KIND_PALLET: begin
            if (data[64]) pallet_latched = 1'b1;
         end
         KIND_TICK: begin
            if (!stopped) begin
               cmd = '0;
               if (pallet_latched || dist_sum >= cfg_target) begin
                  stopped = 1'b1;
                  cmd.halted = 1'b1;
                  cmd.by_pallet = pallet_latched;
               end else begin
                  goal = longint'(cfg_target);
                  twice = 2 * longint'(dist_sum);
                  pk = longint'(cfg_peak);
                  fl = longint'(cfg_floor);
                  if (twice < goal) v = fl + ((pk - fl) * twice) / goal;
                  else v = pk + ((fl - pk) * (twice - goal)) / goal;
                  if (cfg_reverse) v = -v;
                  cmd.speed = v[15:0];
                  cmd.steer = cfg_steer;
               end
               pending_cmds.push_back(cmd);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_target = '0;
         cfg_peak = PEAK_RESET;
         cfg_floor = FLOOR_RESET;
         cfg_steer = '0;
         cfg_reverse = 1'b1;
         dist_sum = '0;
         prev_x = '0;
         prev_y = '0;
         seen_pose = 1'b0;
         pallet_latched = 1'b0;
         stopped = 1'b0;
         fail_count = 0;
         pending_cmds.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_TARGET_DIST: cfg_target = csr_wdata;
               CSR_PEAK_SPEED:  cfg_peak = csr_wdata[SPEED_W-1:0];
               CSR_FLOOR_SPEED: cfg_floor = csr_wdata[SPEED_W-1:0];
               CSR_STEER_CMD:   cfg_steer = csr_wdata[OUT_W-1:0];
               CSR_REVERSE_DIR: cfg_reverse = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[33:0];
            if (pending_cmds.size() == 0) begin
               note_failure($sformatf("command with none due: speed %0d steer %0d halt %b pallet %b",
                  $signed(got.speed), $signed(got.steer), got.halted, got.by_pallet));
            end else begin
               want = pending_cmds.pop_front();
               if (got.speed !== want.speed)
                  note_failure($sformatf("speed_out expected %0d got %0d",
                     $signed(want.speed), $signed(got.speed)));
               if (got.steer !== want.steer)
                  note_failure($sformatf("steer_out expected %0d got %0d",
                     $signed(want.steer), $signed(got.steer)));
               if (got.halted !== want.halted)
                  note_failure($sformatf("halted expected %b got %b", want.halted, got.halted));
               if (got.by_pallet !== want.by_pallet)
                  note_failure($sformatf("stop_by_pallet expected %b got %b",
                     want.by_pallet, got.by_pallet));
            end
         end
         if (req_tvalid && req_tready) begin
            absorb_item(req_tuser, req_tdata);
         end
      end
      cmds_due <= pending_cmds.size();
      walked <= dist_sum;
   end

endmodule

[tb/testbench.sv]
// testbench: stimulus and verdict for the distance velocity profiler
// bursty pose, pallet and tick traffic over several profile settings, stalling receiver
// depends on dvp_pkg, velocity_cmd_checker and the distance_velocity_profiler rtl
module testbench
   import dvp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [REQ_USER_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_UNUSED = 3'd5;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 115;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int               fail_count;
   int               cmds_due;
   logic [POS_W-1:0] walked;

   longint cur_x = 0;
   longint cur_y = 0;
   int     burst_left = 0;
   int     cycles = 0;
   int     stall_mode = 0;
   int     mode_left = 0;
   int     hold_left = 0;

   distance_velocity_profiler dut (.*);

   velocity_cmd_checker checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: always ready, coin flips, or long holds, in randomly switching modes
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left <= $urandom_range(50, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: begin
               if ($urandom_range(0, 7) == 0) begin
                  rsp_tready <= 1'b0;
                  hold_left <= $urandom_range(1, 20);
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   task automatic push_item(input logic [REQ_USER_W-1:0] kind, input logic [31:0] x,
                            input logic [31:0] y, input logic flag);
      req_tdata <= {7'd0, flag, y, x};
      req_tuser <= kind;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   task automatic send_pose(input longint x, input longint y);
      cur_x = x;
      cur_y = y;
      push_item(KIND_POSE, x[31:0], y[31:0], 1'($urandom_range(0, 1)));
   endtask

   task automatic send_tick();
      push_item(KIND_TICK, $urandom, $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper bits of the narrow registers carry junk
   task automatic program_profile(input logic [31:0] target, input logic [14:0] peak,
                                  input logic [14:0] floor_v, input logic [15:0] steer,
                                  input logic rev);
      logic [31:0] junk;
      junk = $urandom;
      write_reg(CSR_TARGET_DIST, target);
      write_reg(CSR_PEAK_SPEED, {junk[16:0], peak});
      write_reg(CSR_FLOOR_SPEED, {junk[31:15], floor_v});
      write_reg(CSR_STEER_CMD, {junk[15:0], steer});
      write_reg(CSR_REVERSE_DIR, {junk[31:1], rev});
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (cmds_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [14:0] speed_value();
      case ($urandom_range(0, 5))
         0: return 15'd0;
         1: return 15'h7FFF;
         default: return 15'($urandom);
      endcase
   endfunction

   initial begin
      longint goal;
      longint bound;
      longint dx;
      longint dy;
      longint reach;
      int     dmax;
      int     pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first pose, exact 3-4-5 step, exact half distance, zero step
      program_profile(32'h0010_0000, 15'h7FFF, 15'd0, 16'h8000, 1'b0);
      send_tick();
      send_pose(0, 0);
      send_tick();
      send_pose(64'sh3_0000, 64'sh4_0000);
      send_tick();
      send_pose(64'sh3_0000, 64'sh7_0000);
      send_tick();
      push_item(KIND_PALLET, $urandom, $urandom, 1'b0);
      push_item(KIND_UNUSED, $urandom, $urandom, 1'b1);
      send_tick();
      send_pose(0, 0);
      send_pose(0, 0);
      send_tick();
      send_pose(-1, -1);
      send_tick();
      settle();

      // falling profile, reversed, plus writes to unmapped indexes
      for (int k = 0; k < 3; k++) write_reg(CSR_FIRST_UNUSED + 3'(k), $urandom);
      program_profile(32'hFFFF_FFFF, 15'd0, 15'h7FFF, 16'h7FFF, 1'b1);
      send_tick();
      send_pose(-64'sh12345, 64'sh6789);
      send_tick();
      send_tick();
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         dmax = 1 << (4 * $urandom_range(2, 5));
         if ($urandom_range(0, 7) == 0) begin
            goal = 64'hFFFF_FFFF;
         end else begin
            goal = longint'(walked) + longint'($urandom_range(1, PHASE_ITEMS * dmax));
            if (goal > 64'hFFFF_FFFF) goal = 64'hFFFF_FFFF;
         end
         if ($urandom_range(0, 3) == 0) write_reg(CSR_FIRST_UNUSED + 3'($urandom_range(0, 2)),
                                                  $urandom);
         program_profile(goal[31:0], speed_value(), speed_value(), 16'($urandom),
                         1'($urandom_range(0, 1)));
         // distance can only grow by at most |dx|+|dy| per pose, keep it short of the goal
         bound = longint'(walked);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               dx = longint'($urandom_range(0, 2 * dmax)) - dmax;
               dy = longint'($urandom_range(0, 2 * dmax)) - dmax;
               reach = ((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy);
               if (bound + reach + 1 >= goal) begin
                  dx = 0;
                  dy = 0;
               end else begin
                  bound = bound + reach;
               end
               send_pose(cur_x + dx, cur_y + dy);
            end else if (pick < 85) begin
               send_tick();
            end else if (pick < 95) begin
               push_item(KIND_PALLET, $urandom, $urandom, 1'b0);
            end else begin
               push_item(KIND_UNUSED, $urandom, $urandom, 1'($urandom_range(0, 1)));
            end
         end
         settle();
      end

      // zero target, saturating step, optional pallet stop, then silence
      program_profile(32'd0, speed_value(), speed_value(), 16'($urandom),
                      1'($urandom_range(0, 1)));
      send_pose(-64'sd2147483648, -64'sd2147483648);
      send_pose(64'sd2147483647, 64'sd2147483647);
      if ($urandom_range(0, 1) == 1) push_item(KIND_PALLET, $urandom, $urandom, 1'b1);
      send_tick();
      for (int i = 0; i < 30; i++) begin
         pick = $urandom_range(0, 3);
         case (pick)
            0: send_pose(longint'($signed(32'($urandom))), longint'($signed(32'($urandom))));
            1: push_item(KIND_PALLET, $urandom, $urandom, 1'($urandom_range(0, 1)));
            2: send_tick();
            default: push_item(KIND_UNUSED, $urandom, $urandom, 1'($urandom_range(0, 1)));
         endcase
      end
      settle();

      if (fail_count == 0 && cmds_due == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
